FILE: src/teq_pkg.sv
// teq_pkg: shared types and field widths of the timed event queue
// no dependencies

package teq_pkg;

  localparam int TIME_W   = 32;
  localparam int HANDLE_W = 16;
  localparam int PRIO_W   = 2;
  localparam int EVID_W   = 16;
  localparam int OUT_ID_W = 16;

  typedef enum logic [1:0] {
    FN_SCHEDULE = 2'd0,
    FN_REMOVE   = 2'd1,
    FN_TICK     = 2'd2,
    FN_CLEAR    = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_NOT_FOUND = 2'd1,
    STS_FULL      = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_DN,
    S_SCAN_UP,
    S_INSERT,
    S_DONE
  } state_e;

endpackage

FILE: src/timed_event_queue_unit.sv
// timed_event_queue_unit: table of pending timed events sorted by due time
// depends on teq_pkg and teq_ram
//
// channel  direction  handshake               payload
// in       input      in_valid_i / in_stall_o  func, current_time, time_value, is_relative,
//                                              job_handle, job_priority, long_lived, event_id
// out      output     out_valid_o / out_stall_i status, assigned_id, dispatched, out_handle,
//                                              out_priority, out_long_lived, out_id
//
// schedule walks down from the tail and remove and tick walk up from the head; clear,
// schedule into a full or empty table, and remove or tick on an empty table skip the walk;
// the table lives in one memory walked one entry per cycle
// insertion and removal shift entries through the memory's single write port
// in_stall_o is high from acceptance until the result sits in the output register
// a result waits in the output register while out_stall_i is high
// reset empties the table and clears the id counter; no clearing pass is needed

module timed_event_queue_unit
  import teq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_BITS     = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          func_i,
  input  logic [TIME_W-1:0]   current_time_i,
  input  logic [TIME_W-1:0]   time_value_i,
  input  logic                is_relative_i,
  input  logic [HANDLE_W-1:0] job_handle_i,
  input  logic [PRIO_W-1:0]   job_priority_i,
  input  logic                long_lived_i,
  input  logic [EVID_W-1:0]   event_id_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          status_o,
  output logic [OUT_ID_W-1:0] assigned_id_o,
  output logic                dispatched_o,
  output logic [HANDLE_W-1:0] out_handle_o,
  output logic [PRIO_W-1:0]   out_priority_o,
  output logic                out_long_lived_o,
  output logic [OUT_ID_W-1:0] out_id_o
);

  localparam int AW    = $clog2(QUEUE_DEPTH);
  localparam int CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int EW    = TIME_W + ID_BITS + HANDLE_W + PRIO_W + 1;
  localparam int CMP_W = (ID_BITS > EVID_W) ? ID_BITS : EVID_W;

  state_e state_q, state_d;

  func_e               op_q, op_d;
  logic [TIME_W-1:0]   cur_time_q, cur_time_d;
  logic [TIME_W-1:0]   due_q, due_d;
  logic [HANDLE_W-1:0] handle_q, handle_d;
  logic [PRIO_W-1:0]   prio_q, prio_d;
  logic                persist_q, persist_d;
  logic [EVID_W-1:0]   rm_id_q, rm_id_d;
  logic [CW-1:0]       ptr_q, ptr_d;
  logic                pend_q, pend_d;
  logic                found_q, found_d;
  logic [AW-1:0]       ins_q, ins_d;
  logic [CW-1:0]       count_q, count_d;
  logic [ID_BITS-1:0]  next_id_q, next_id_d;

  status_e             res_status_q, res_status_d;
  logic [OUT_ID_W-1:0] res_assigned_q, res_assigned_d;
  logic                res_disp_q, res_disp_d;
  logic [HANDLE_W-1:0] res_handle_q, res_handle_d;
  logic [PRIO_W-1:0]   res_prio_q, res_prio_d;
  logic                res_persist_q, res_persist_d;
  logic [OUT_ID_W-1:0] res_id_q, res_id_d;

  logic                out_valid_q, out_valid_d;
  status_e             out_status_q, out_status_d;
  logic [OUT_ID_W-1:0] out_assigned_q, out_assigned_d;
  logic                out_disp_q, out_disp_d;
  logic [HANDLE_W-1:0] out_handle_q, out_handle_d;
  logic [PRIO_W-1:0]   out_prio_q, out_prio_d;
  logic                out_persist_q, out_persist_d;
  logic [OUT_ID_W-1:0] out_id_q, out_id_d;

  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [EW-1:0]       wr_data;
  logic [AW-1:0]       rd_addr;
  logic [EW-1:0]       rd_data;

  logic [TIME_W-1:0]   rd_time;
  logic [ID_BITS-1:0]  rd_id;
  logic [HANDLE_W-1:0] rd_handle;
  logic [PRIO_W-1:0]   rd_prio;
  logic                rd_persist;

  logic                in_acc;
  logic                out_free;
  logic                full;
  logic                empty;
  logic [TIME_W:0]     rel_sum;
  logic [TIME_W-1:0]   due_new;
  logic [CW-1:0]       cnt_m1;
  logic [CW-1:0]       pos_dn;
  logic [CW-1:0]       pos_dn_p1;
  logic [CW-1:0]       pos_up;
  logic [CW-1:0]       pos_up_m1;
  logic                time_ge;
  logic                hit_up;
  logic                done_dn;
  logic                done_up;
  logic                gone;

  teq_ram #(
    .WIDTH(EW),
    .DEPTH(QUEUE_DEPTH)
  ) u_table (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  assign rd_time    = rd_data[TIME_W-1:0];
  assign rd_id      = rd_data[TIME_W +: ID_BITS];
  assign rd_handle  = rd_data[TIME_W + ID_BITS +: HANDLE_W];
  assign rd_prio    = rd_data[TIME_W + ID_BITS + HANDLE_W +: PRIO_W];
  assign rd_persist = rd_data[EW-1];

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign full       = (count_q == CW'(QUEUE_DEPTH));
  assign empty      = (count_q == '0);

  // saturating due time for relative scheduling
  assign rel_sum = {1'b0, current_time_i} + {1'b0, time_value_i};
  assign due_new = !is_relative_i ? time_value_i :
                   (rel_sum[TIME_W] ? {TIME_W{1'b1}} : rel_sum[TIME_W-1:0]);

  assign cnt_m1    = count_q - CW'(1);
  assign pos_dn    = ptr_q + CW'(1);
  assign pos_dn_p1 = pos_dn + CW'(1);
  assign pos_up    = ptr_q - CW'(1);
  assign pos_up_m1 = pos_up - CW'(1);

  assign time_ge = (rd_time >= due_q);
  assign hit_up  = !found_q && ((op_q == FN_REMOVE) ?
                   (CMP_W'(rd_id) == CMP_W'(rm_id_q)) : (cur_time_q >= rd_time));
  assign done_dn = !time_ge || (pos_dn == '0);
  assign done_up = (pos_up == cnt_m1) || (!found_q && !hit_up && (op_q == FN_TICK));
  assign gone    = found_q || hit_up;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          unique case (func_e'(func_i))
            FN_SCHEDULE: begin
              if (full) begin
                state_d = S_DONE;
              end else if (empty) begin
                state_d = S_INSERT;
              end else begin
                state_d = S_SCAN_DN;
              end
            end
            FN_REMOVE, FN_TICK: begin
              state_d = empty ? S_DONE : S_SCAN_UP;
            end
            FN_CLEAR: begin
              state_d = S_DONE;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_SCAN_DN: begin
        if (pend_q && done_dn) begin
          state_d = S_INSERT;
        end
      end
      S_SCAN_UP: begin
        if (pend_q && done_up) begin
          state_d = S_DONE;
        end
      end
      S_INSERT: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // datapath and table control
  always_comb begin
    op_d           = op_q;
    cur_time_d     = cur_time_q;
    due_d          = due_q;
    handle_d       = handle_q;
    prio_d         = prio_q;
    persist_d      = persist_q;
    rm_id_d        = rm_id_q;
    ptr_d          = ptr_q;
    pend_d         = pend_q;
    found_d        = found_q;
    ins_d          = ins_q;
    count_d        = count_q;
    next_id_d      = next_id_q;
    res_status_d   = res_status_q;
    res_assigned_d = res_assigned_q;
    res_disp_d     = res_disp_q;
    res_handle_d   = res_handle_q;
    res_prio_d     = res_prio_q;
    res_persist_d  = res_persist_q;
    res_id_d       = res_id_q;
    out_valid_d    = out_valid_q && out_stall_i;
    out_status_d   = out_status_q;
    out_assigned_d = out_assigned_q;
    out_disp_d     = out_disp_q;
    out_handle_d   = out_handle_q;
    out_prio_d     = out_prio_q;
    out_persist_d  = out_persist_q;
    out_id_d       = out_id_q;
    wr_en          = 1'b0;
    wr_addr        = '0;
    wr_data        = rd_data;
    rd_addr        = AW'(ptr_q);

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          op_d           = func_e'(func_i);
          cur_time_d     = current_time_i;
          due_d          = due_new;
          handle_d       = job_handle_i;
          prio_d         = job_priority_i;
          persist_d      = long_lived_i;
          rm_id_d        = event_id_i;
          pend_d         = 1'b0;
          found_d        = 1'b0;
          ins_d          = '0;
          ptr_d          = (func_e'(func_i) == FN_SCHEDULE) ? cnt_m1 : '0;
          res_status_d   = STS_OK;
          res_assigned_d = '0;
          res_disp_d     = 1'b0;
          res_handle_d   = '0;
          res_prio_d     = '0;
          res_persist_d  = 1'b0;
          res_id_d       = '0;
          unique case (func_e'(func_i))
            FN_SCHEDULE: begin
              if (full) begin
                res_status_d = STS_FULL;
              end
            end
            FN_REMOVE: begin
              if (empty) begin
                res_status_d = STS_NOT_FOUND;
              end
            end
            FN_TICK: begin
            end
            FN_CLEAR: begin
              count_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN_DN: begin
        // walk down from the tail, shifting later entries up by one
        ptr_d  = ptr_q - CW'(1);
        pend_d = 1'b1;
        if (pend_q) begin
          ins_d = AW'(time_ge ? pos_dn : pos_dn_p1);
          if (time_ge) begin
            wr_en   = 1'b1;
            wr_addr = AW'(pos_dn_p1);
          end
        end
      end
      S_SCAN_UP: begin
        // walk up from the head, closing the gap behind the hit
        ptr_d  = ptr_q + CW'(1);
        pend_d = 1'b1;
        if (pend_q) begin
          if (found_q) begin
            wr_en   = 1'b1;
            wr_addr = AW'(pos_up_m1);
          end else if (hit_up) begin
            found_d = 1'b1;
            if (op_q == FN_TICK) begin
              res_disp_d    = 1'b1;
              res_handle_d  = rd_handle;
              res_prio_d    = rd_prio;
              res_persist_d = rd_persist;
              res_id_d      = OUT_ID_W'(rd_id);
            end
          end
          if (done_up) begin
            if (gone) begin
              count_d = count_q - CW'(1);
            end
            if (op_q == FN_REMOVE) begin
              res_status_d = gone ? STS_OK : STS_NOT_FOUND;
            end
          end
        end
      end
      S_INSERT: begin
        wr_en          = 1'b1;
        wr_addr        = ins_q;
        wr_data        = {persist_q, prio_q, handle_q, next_id_q, due_q};
        count_d        = count_q + CW'(1);
        res_assigned_d = OUT_ID_W'(next_id_q);
        next_id_d      = next_id_q + ID_BITS'(1);
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d    = 1'b1;
          out_status_d   = res_status_q;
          out_assigned_d = res_assigned_q;
          out_disp_d     = res_disp_q;
          out_handle_d   = res_handle_q;
          out_prio_d     = res_prio_q;
          out_persist_d  = res_persist_q;
          out_id_d       = res_id_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      next_id_q   <= '0;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
      found_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      next_id_q   <= next_id_d;
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
      found_q     <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q           <= op_d;
    cur_time_q     <= cur_time_d;
    due_q          <= due_d;
    handle_q       <= handle_d;
    prio_q         <= prio_d;
    persist_q      <= persist_d;
    rm_id_q        <= rm_id_d;
    ptr_q          <= ptr_d;
    ins_q          <= ins_d;
    res_status_q   <= res_status_d;
    res_assigned_q <= res_assigned_d;
    res_disp_q     <= res_disp_d;
    res_handle_q   <= res_handle_d;
    res_prio_q     <= res_prio_d;
    res_persist_q  <= res_persist_d;
    res_id_q       <= res_id_d;
    out_status_q   <= out_status_d;
    out_assigned_q <= out_assigned_d;
    out_disp_q     <= out_disp_d;
    out_handle_q   <= out_handle_d;
    out_prio_q     <= out_prio_d;
    out_persist_q  <= out_persist_d;
    out_id_q       <= out_id_d;
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign assigned_id_o    = out_assigned_q;
  assign dispatched_o     = out_disp_q;
  assign out_handle_o     = out_handle_q;
  assign out_priority_o   = out_prio_q;
  assign out_long_lived_o = out_persist_q;
  assign out_id_o         = out_id_q;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(QUEUE_DEPTH))
    else $error("entry count above table depth");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (CW'(wr_addr) <= count_q) && (CW'(wr_addr) < CW'(QUEUE_DEPTH)))
    else $error("table write outside the occupied range");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && func_e'(func_i) == FN_CLEAR) |=> empty)
    else $error("clear left entries in the table");

  a_insert_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INSERT) |=> (next_id_q == $past(next_id_q) + ID_BITS'(1))
      && (count_q == $past(count_q) + CW'(1)))
    else $error("insert did not advance id and count");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result transaction raised outside the done state");
`endif

endmodule

FILE: src/teq_ram.sv
// teq_ram: generic single-write, single-read memory with registered read data
// no dependencies

module teq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule
